// File: rtl/blc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and pattern tables for the line classifier.
// No dependencies; used by every module of the block.
package blc_pkg;

	typedef enum logic [2:0] {
		CLS_UNKNOWN     = 3'd0,
		CLS_YENC_MULTI  = 3'd1,
		CLS_YENC_SINGLE = 3'd2,
		CLS_UU_SINGLE   = 3'd3,
		CLS_UU_MULTI    = 3'd4
	} enc_class_t;

	// Phases of the multipart header matcher
	typedef enum logic [7:0] {
		PH_PREFIX     = 8'b0000_0001,
		PH_NEED_SPACE = 8'b0000_0010,
		PH_SPACES     = 8'b0000_0100,
		PH_KEY        = 8'b0000_1000,
		PH_NEED_DIGIT = 8'b0001_0000,
		PH_DIGITS     = 8'b0010_0000,
		PH_MATCH      = 8'b0100_0000,
		PH_FAIL       = 8'b1000_0000
	} mphase_t;

	// Header keywords, in the order they may appear
	typedef enum logic [2:0] {
		KR_NONE   = 3'd0,
		KR_PART   = 3'd1,
		KR_TOTAL  = 3'd2,
		KR_LINE_A = 3'd3,
		KR_SIZE   = 3'd4,
		KR_LINE_B = 3'd5,
		KR_NAME   = 3'd6
	} key_rank_t;

	typedef struct packed {
		mphase_t   phase;
		logic [2:0] pos;
		key_rank_t rank;
	} multi_st_t;

	typedef struct packed {
		logic [4:0] single_st;
		logic [3:0] begin_st;
	} lin_st_t;

	typedef enum logic [1:0] {
		TK_CHAR   = 2'd0,
		TK_SPACES = 2'd1,
		TK_DIGITS = 2'd2,
		TK_DIGIT  = 2'd3
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] ch;
	} tok_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UPPER_M = 8'h4D;

	localparam int unsigned SINGLE_N = 27;
	localparam int unsigned BEGIN_N = 10;
	localparam logic [4:0] SINGLE_LEN = 5'(SINGLE_N);
	localparam logic [3:0] BEGIN_LEN = 4'(BEGIN_N);
	localparam logic [4:0] LIN_FAIL = 5'd31;
	localparam logic [6:0] LEN_SAT = 7'd127;
	localparam logic [6:0] UU_LEN_LO = 7'd61;
	localparam logic [6:0] UU_LEN_HI = 7'd63;
	localparam logic [2:0] PREFIX_LAST = 3'd6;

	// '_' one or more spaces, '#' one or more digits, 'd' exactly one digit
	localparam logic [8*SINGLE_N-1:0] SINGLE_PAT = "=ybegin_line=#_size=#_name=";
	localparam logic [8*BEGIN_N-1:0] BEGIN_PAT = "begin_ddd_";
	localparam logic [55:0] YB_PREFIX = "=ybegin";

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c);
		return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
	endfunction

	function automatic tok_t to_tok(input logic [7:0] ch);
		tok_t t;
		t.ch = ch;
		case (ch)
			"_": t.kind = TK_SPACES;
			"#": t.kind = TK_DIGITS;
			"d": t.kind = TK_DIGIT;
			default: t.kind = TK_CHAR;
		endcase
		return t;
	endfunction

	function automatic tok_t single_tok(input logic [4:0] i);
		logic [7:0] ch;
		ch = 8'h00;
		if (i < SINGLE_LEN)
			ch = SINGLE_PAT[8*(SINGLE_N-1-int'(i)) +: 8];
		return to_tok(ch);
	endfunction

	function automatic tok_t begin_tok(input logic [3:0] i);
		logic [7:0] ch;
		ch = 8'h00;
		if (i < BEGIN_LEN)
			ch = BEGIN_PAT[8*(BEGIN_N-1-int'(i)) +: 8];
		return to_tok(ch);
	endfunction

	function automatic logic tok_ok(input tok_t t, input logic [7:0] c);
		logic ok;
		case (t.kind)
			TK_SPACES: ok = (c == CH_SPACE);
			TK_DIGITS, TK_DIGIT: ok = is_digit(c);
			default: ok = (c == t.ch);
		endcase
		return ok;
	endfunction

	// One step of a linear pattern matcher
	function automatic logic [4:0] lin_step(input logic [4:0] s, input logic [4:0] len,
			input tok_t cur, input tok_t prev, input tok_t first, input logic anchored,
			input logic [7:0] c);
		logic [4:0] n;
		if (s == len)
			n = s;
		else if (s > len)
			n = LIN_FAIL;
		else if ((s != 5'd0) && (((prev.kind == TK_SPACES) && (c == CH_SPACE)) ||
				((prev.kind == TK_DIGITS) && is_digit(c))))
			n = s;
		else if (tok_ok(cur, c))
			n = s + 5'd1;
		else if (anchored)
			n = LIN_FAIL;
		else
			n = tok_ok(first, c) ? 5'd1 : 5'd0;
		return n;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] i);
		logic [7:0] ch;
		ch = 8'h00;
		if (i <= PREFIX_LAST)
			ch = YB_PREFIX[8*(6-int'(i)) +: 8];
		return ch;
	endfunction

	function automatic logic [2:0] key_len(input key_rank_t r);
		logic [2:0] n;
		case (r)
			KR_PART, KR_LINE_A, KR_SIZE, KR_LINE_B, KR_NAME: n = 3'd5;
			KR_TOTAL: n = 3'd6;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] key_char(input key_rank_t r, input logic [2:0] p);
		logic [47:0] txt;
		logic [7:0] ch;
		case (r)
			KR_PART: txt = {"part=", 8'h00};
			KR_TOTAL: txt = "total=";
			KR_LINE_A, KR_LINE_B: txt = {"line=", 8'h00};
			KR_SIZE: txt = {"size=", 8'h00};
			KR_NAME: txt = {"name=", 8'h00};
			default: txt = '0;
		endcase
		ch = 8'h00;
		if (p <= 3'd5)
			ch = txt[8*(5-int'(p)) +: 8];
		return ch;
	endfunction

	// Rank reached by a keyword's first letter; a "line" takes the earlier slot if it can
	function automatic key_rank_t key_start(input logic [7:0] c, input key_rank_t r);
		key_rank_t n;
		n = KR_NONE;
		if (r == KR_NONE) begin
			if (c == "p")
				n = KR_PART;
		end else begin
			case (c)
				"t": n = (r == KR_PART) ? KR_TOTAL : KR_NONE;
				"l": n = (r <= KR_TOTAL) ? KR_LINE_A : ((r <= KR_SIZE) ? KR_LINE_B : KR_NONE);
				"s": n = (r <= KR_LINE_A) ? KR_SIZE : KR_NONE;
				"n": n = KR_NAME;
				default: n = KR_NONE;
			endcase
		end
		return n;
	endfunction

endpackage

// File: rtl/binary_encoding_line_classifier.sv
`timescale 1ns / 1ps
// Binary news encoding line classifier, top level.
// Uses blc_pkg, blc_multi_hdr and blc_lin_match.
//
// Input channel (item_valid / item_stall): one byte of a text line per item
// in char_byte, qualified by byte_present; line_end marks the last item of a
// line. An item with line_end and no byte ends the line without adding to it,
// so a line made only of such an item is empty and classifies as unknown.
// Output channel (result_valid / result_stall): one encoding_class per line,
// given for the item that carries line_end: 0 unknown, 1 yEnc multipart,
// 2 yEnc single part, 3 uuencode single, 4 uuencode multipart body.
// Throughput is one item per cycle unless a line-end item is held: the
// accepted item sits in an input register and the three matchers advance
// in small logic into the state and result registers. A line-end item
// passes from the input register to the result register as its class.
// When the result is stalled, items without line_end keep flowing; a further
// line-end item waits in the input register and then item_stall rises.
// Reset clears both channels and returns every matcher to start of line;
// every line end does the same for the matchers.
module binary_encoding_line_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] char_byte,
	input  logic       byte_present,
	input  logic       line_end,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] encoding_class
);
	import blc_pkg::*;

	localparam multi_st_t MULTI_START = '{phase: PH_PREFIX, pos: 3'd0, rank: KR_NONE};
	localparam lin_st_t LIN_START = '{single_st: 5'd0, begin_st: 4'd0};

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       last_s1;

	multi_st_t  multi_q, multi_nxt, multi_upd;
	lin_st_t    lin_q, lin_nxt, lin_upd;
	logic       first_m_q, first_m_upd;
	logic [6:0] len_q, len_upd;

	logic       result_valid_q;
	enc_class_t class_q, cls;

	logic       fire_s1;
	logic       accept;
	logic [7:0] folded;

	assign folded = fold(byte_s1);

	// a line-end item moves on only when the result register can take its class
	assign fire_s1 = valid_s1 && (!last_s1 || !result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !fire_s1;
	assign accept = item_valid && !item_stall;

	blc_multi_hdr u_multi (
		.cur (multi_q),
		.c   (folded),
		.nxt (multi_nxt)
	);

	blc_lin_match u_lin (
		.cur (lin_q),
		.c   (folded),
		.nxt (lin_nxt)
	);

	always_comb begin
		multi_upd = multi_q;
		lin_upd = lin_q;
		first_m_upd = first_m_q;
		len_upd = len_q;
		if (present_s1) begin
			multi_upd = multi_nxt;
			lin_upd = lin_nxt;
			if (len_q == 7'd0)
				first_m_upd = (byte_s1 == CH_UPPER_M);
			if (len_q != LEN_SAT)
				len_upd = len_q + 7'd1;
		end
	end

	always_comb begin
		if (len_upd == 7'd0)
			cls = CLS_UNKNOWN;
		else if (multi_upd.phase == PH_MATCH)
			cls = CLS_YENC_MULTI;
		else if (lin_upd.single_st == SINGLE_LEN)
			cls = CLS_YENC_SINGLE;
		else if (lin_upd.begin_st == BEGIN_LEN)
			cls = CLS_UU_SINGLE;
		else if (first_m_upd && (len_upd inside {[UU_LEN_LO:UU_LEN_HI]}))
			cls = CLS_UU_MULTI;
		else
			cls = CLS_UNKNOWN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= char_byte;
			present_s1 <= byte_present;
			last_s1 <= line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_q <= MULTI_START;
			lin_q <= LIN_START;
			first_m_q <= 1'b0;
			len_q <= 7'd0;
		end else if (fire_s1) begin
			if (last_s1) begin
				multi_q <= MULTI_START;
				lin_q <= LIN_START;
				first_m_q <= 1'b0;
				len_q <= 7'd0;
			end else begin
				multi_q <= multi_upd;
				lin_q <= lin_upd;
				first_m_q <= first_m_upd;
				len_q <= len_upd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1)
			class_q <= cls;
	end

	assign result_valid = result_valid_q;
	assign encoding_class = class_q;

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (class_q <= CLS_UU_MULTI))
		else $error("class code out of range");

	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> ((multi_q.phase == PH_PREFIX) && (len_q == 7'd0) &&
			(lin_q.single_st == 5'd0) && (lin_q.begin_st == 4'd0)))
		else $error("matchers not back at start of line after line end");

	a_rank_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(multi_q.phase == PH_PREFIX) |-> (multi_q.rank == KR_NONE))
		else $error("keyword rank set before the header prefix completed");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && last_s1 && result_valid_q))
		else $error("input stalled without a blocked line-end item");

endmodule

// File: rtl/blc_multi_hdr.sv
`timescale 1ns / 1ps
// Next-state logic of the anchored yEnc multipart header matcher.
// Depends on blc_pkg.
module blc_multi_hdr (
	input  blc_pkg::multi_st_t cur,
	input  logic [7:0]         c,
	output blc_pkg::multi_st_t nxt
);
	import blc_pkg::*;

	key_rank_t nr;
	logic [2:0] klen;

	always_comb begin
		nxt = cur;
		nr = key_start(c, cur.rank);
		klen = key_len(cur.rank);
		case (cur.phase)
			PH_PREFIX: begin
				if (c != prefix_char(cur.pos)) begin
					nxt.phase = PH_FAIL;
				end else if (cur.pos == PREFIX_LAST) begin
					nxt.phase = PH_NEED_SPACE;
					nxt.pos = 3'd0;
				end else begin
					nxt.pos = cur.pos + 3'd1;
				end
			end
			PH_NEED_SPACE: begin
				nxt.phase = (c == CH_SPACE) ? PH_SPACES : PH_FAIL;
			end
			PH_SPACES: begin
				if (c != CH_SPACE) begin
					if (nr == KR_NONE) begin
						nxt.phase = PH_FAIL;
					end else begin
						nxt.rank = nr;
						nxt.phase = PH_KEY;
						nxt.pos = 3'd1;
					end
				end
			end
			PH_KEY: begin
				if ((cur.rank == KR_NONE) || (cur.pos >= klen) ||
						(c != key_char(cur.rank, cur.pos))) begin
					nxt.phase = PH_FAIL;
				end else if (cur.pos + 3'd1 == klen) begin
					nxt.phase = (cur.rank == KR_NAME) ? PH_MATCH : PH_NEED_DIGIT;
				end else begin
					nxt.pos = cur.pos + 3'd1;
				end
			end
			PH_NEED_DIGIT: begin
				nxt.phase = is_digit(c) ? PH_DIGITS : PH_FAIL;
			end
			PH_DIGITS: begin
				if (c == CH_SPACE)
					nxt.phase = PH_SPACES;
				else if (!is_digit(c))
					nxt.phase = PH_FAIL;
			end
			PH_MATCH: begin
				nxt.phase = PH_MATCH;
			end
			default: begin
				nxt.phase = PH_FAIL;
			end
		endcase
	end

endmodule

// File: rtl/blc_lin_match.sv
`timescale 1ns / 1ps
// Next-state logic of the single-part header matcher (anchored) and the
// uuencode "begin" search (anywhere in the line). Depends on blc_pkg.
module blc_lin_match (
	input  blc_pkg::lin_st_t cur,
	input  logic [7:0]       c,
	output blc_pkg::lin_st_t nxt
);
	import blc_pkg::*;

	logic [4:0] beg_next;

	always_comb begin
		nxt.single_st = lin_step(cur.single_st, SINGLE_LEN, single_tok(cur.single_st),
			single_tok(cur.single_st - 5'd1), single_tok(5'd0), 1'b1, c);
		beg_next = lin_step({1'b0, cur.begin_st}, {1'b0, BEGIN_LEN},
			begin_tok(cur.begin_st), begin_tok(cur.begin_st - 4'd1), begin_tok(4'd0),
			1'b0, c);
		// the search never fails, so its state stays within the pattern length
		nxt.begin_st = beg_next[3:0];
	end

endmodule
